// ===== sv/button_press_classifier_defines.svh =====
// ----------------------------------------------------------------------------
// button_press_classifier_defines
// Assertion macros shared by the button press classifier RTL.
// ----------------------------------------------------------------------------
`ifndef BUTTON_PRESS_CLASSIFIER_DEFINES_SVH
`define BUTTON_PRESS_CLASSIFIER_DEFINES_SVH

`ifndef SYNTHESIS
`define BPC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bpc assertion failed");
`define BPC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bpc assertion failed");
`else
`define BPC_ASSERT_IMP(label, ante, cons)
`define BPC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== sv/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpc_pkg
// Types and constants of the button press classifier.
// ----------------------------------------------------------------------------
package bpc_pkg;

	localparam int TIME_WIDTH = 32;
	localparam int CFG_W      = 16;
	localparam int STATUS_W   = 3;

	localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd20;
	localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd1000;

	typedef logic [TIME_WIDTH-1:0] time_t;
	typedef logic [CFG_W-1:0]      cfg_t;

	typedef enum logic [0:0] {
		CFG_DEBOUNCE   = 1'b0,
		CFG_LONG_PRESS = 1'b1
	} cfg_idx_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_IDLE     = 3'd0,
		ST_DEBOUNCE = 3'd1,
		ST_PRESSED  = 3'd2,
		ST_RELEASED = 3'd3,
		ST_LONG     = 3'd4,
		ST_HOLDING  = 3'd5,
		ST_LONGLONG = 3'd6
	} state_t;

endpackage

// ===== sv/bpc_in_if.sv =====
// ----------------------------------------------------------------------------
// bpc_in_if
// Poll channel: timestamp and pin level, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bpc_in_if;
	logic                            valid;
	logic                            ready;
	logic [bpc_pkg::TIME_WIDTH-1:0]  now_ms;
	logic                            pin_released;

	modport source (output valid, output now_ms, output pin_released, input ready);
	modport sink   (input valid, input now_ms, input pin_released, output ready);
endinterface

// ===== sv/bpc_out_if.sv =====
// ----------------------------------------------------------------------------
// bpc_out_if
// Status channel: status code and event flag, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bpc_out_if;
	logic                           valid;
	logic                           ready;
	logic [bpc_pkg::STATUS_W-1:0]   status;
	logic                           is_event;

	modport source (output valid, output status, output is_event, input ready);
	modport sink   (input valid, input status, input is_event, output ready);
endinterface

// ===== sv/button_press_classifier.sv =====
// ----------------------------------------------------------------------------
// button_press_classifier
// Debounced push button with release, long press and long-press autorepeat.
// ----------------------------------------------------------------------------
// Each poll item carries a millisecond timestamp and the pin level and yields
// exactly one status item. The block takes one item per clock cycle while the
// output is not held. An item is captured in the input register when it is
// accepted and is presented at the output from the result register, which
// loads it when the item fires. The rate is set by the update of the press
// state and the stored event time when an item fires; the next item reads
// them. A held result stalls the input only while the input register is
// also full.
`include "button_press_classifier_defines.svh"

module button_press_classifier (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [bpc_pkg::CFG_W-1:0] cfg_data,
	bpc_in_if.sink                in_ch,
	bpc_out_if.source             out_ch
);

	logic               valid_s1;
	bpc_pkg::time_t     now_s1;
	logic               pin_s1;

	bpc_pkg::cfg_t      debounce_q;
	bpc_pkg::cfg_t      long_press_q;
	bpc_pkg::state_t    state_q;
	bpc_pkg::time_t     event_time_q;

	logic               out_valid_q;
	bpc_pkg::state_t    status_q;
	logic               is_event_q;

	logic               fire;
	bpc_pkg::time_t     diff;
	bpc_pkg::time_t     elapsed2;
	bpc_pkg::time_t     debounce_ext;
	bpc_pkg::time_t     long_ext;
	bpc_pkg::state_t    upd_state;
	bpc_pkg::state_t    next_state;
	bpc_pkg::state_t    status;
	logic               time_set;
	logic               event_set;
	logic               is_event;

	assign fire        = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || fire;

	assign debounce_ext = {{(bpc_pkg::TIME_WIDTH-bpc_pkg::CFG_W){1'b0}}, debounce_q};
	assign long_ext     = {{(bpc_pkg::TIME_WIDTH-bpc_pkg::CFG_W){1'b0}}, long_press_q};
	assign diff         = now_s1 - event_time_q;

	always_comb begin
		upd_state = state_q;
		time_set  = 1'b0;
		case (state_q)
			bpc_pkg::ST_IDLE: begin
				if (!pin_s1) begin
					upd_state = bpc_pkg::ST_DEBOUNCE;
					time_set  = 1'b1;
				end
			end
			bpc_pkg::ST_DEBOUNCE: begin
				if (diff >= debounce_ext)
					upd_state = bpc_pkg::ST_PRESSED;
			end
			bpc_pkg::ST_PRESSED: begin
				if (pin_s1) begin
					upd_state = bpc_pkg::ST_RELEASED;
				end else if (diff >= long_ext) begin
					upd_state = bpc_pkg::ST_LONG;
					time_set  = 1'b1;
				end
			end
			default: ;
		endcase

		// event time just taken from now: zero elapsed
		elapsed2   = time_set ? '0 : diff;
		status     = upd_state;
		next_state = upd_state;
		event_set  = time_set;
		if (upd_state == bpc_pkg::ST_RELEASED) begin
			next_state = bpc_pkg::ST_IDLE;
		end else if (upd_state inside {bpc_pkg::ST_LONG, bpc_pkg::ST_HOLDING,
				bpc_pkg::ST_LONGLONG}) begin
			if (pin_s1) begin
				next_state = bpc_pkg::ST_IDLE;
			end else if (elapsed2 < long_ext) begin
				next_state = bpc_pkg::ST_HOLDING;
			end else begin
				event_set = 1'b1;
				status    = bpc_pkg::ST_LONGLONG;
			end
		end

		is_event = status inside {bpc_pkg::ST_RELEASED, bpc_pkg::ST_LONG,
			bpc_pkg::ST_LONGLONG};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= bpc_pkg::DEBOUNCE_RESET;
			long_press_q <= bpc_pkg::LONG_PRESS_RESET;
		end else if (cfg_we) begin
			case (bpc_pkg::cfg_idx_t'(cfg_index))
				bpc_pkg::CFG_DEBOUNCE:   debounce_q   <= cfg_data;
				bpc_pkg::CFG_LONG_PRESS: long_press_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			now_s1 <= in_ch.now_ms;
			pin_s1 <= in_ch.pin_released;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= bpc_pkg::ST_IDLE;
			event_time_q <= '0;
		end else if (fire) begin
			state_q <= next_state;
			if (event_set)
				event_time_q <= now_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q   <= status;
			is_event_q <= is_event;
		end
	end

	assign out_ch.valid    = out_valid_q;
	assign out_ch.status   = status_q;
	assign out_ch.is_event = is_event_q;

	`BPC_ASSERT_IMP(a_no_transient_state, 1'b1,
		state_q != bpc_pkg::ST_RELEASED && state_q != bpc_pkg::ST_LONGLONG)
	`BPC_ASSERT_IMP(a_released_goes_idle, out_valid_q && status_q == bpc_pkg::ST_RELEASED,
		state_q == bpc_pkg::ST_IDLE)
	`BPC_ASSERT_IMP(a_long_goes_holding, out_valid_q && status_q == bpc_pkg::ST_LONG,
		state_q == bpc_pkg::ST_HOLDING || state_q == bpc_pkg::ST_IDLE)
	`BPC_ASSERT_NEXT(a_fire_fills_output, fire, out_valid_q)

endmodule
